[rtl/core/cswin_pkg.sv]
`default_nettype none

package cswin_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned REF_W      = 32;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned SLOT_W     = REF_W + LEVEL_W;
  localparam int unsigned WSIZE_W    = 11;
  localparam int unsigned FILTER_W   = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned KIND_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FILTER = 1'd1;

  localparam logic [WSIZE_W-1:0]  WSIZE_RESET  = 11'd1;
  localparam logic [FILTER_W-1:0] FILTER_RESET = 8'd0;

  // Level filter codes; each decimal digit names an accepted level.
  localparam logic [FILTER_W-1:0] FLT_1   = 8'd1;
  localparam logic [FILTER_W-1:0] FLT_2   = 8'd2;
  localparam logic [FILTER_W-1:0] FLT_3   = 8'd3;
  localparam logic [FILTER_W-1:0] FLT_4   = 8'd4;
  localparam logic [FILTER_W-1:0] FLT_12  = 8'd12;
  localparam logic [FILTER_W-1:0] FLT_13  = 8'd13;
  localparam logic [FILTER_W-1:0] FLT_14  = 8'd14;
  localparam logic [FILTER_W-1:0] FLT_23  = 8'd23;
  localparam logic [FILTER_W-1:0] FLT_24  = 8'd24;
  localparam logic [FILTER_W-1:0] FLT_34  = 8'd34;
  localparam logic [FILTER_W-1:0] FLT_123 = 8'd123;
  localparam logic [FILTER_W-1:0] FLT_124 = 8'd124;
  localparam logic [FILTER_W-1:0] FLT_234 = 8'd234;

  localparam logic [LEVEL_W-1:0] LVL_1 = 4'd1;
  localparam logic [LEVEL_W-1:0] LVL_2 = 4'd2;
  localparam logic [LEVEL_W-1:0] LVL_3 = 4'd3;
  localparam logic [LEVEL_W-1:0] LVL_4 = 4'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLUS      = 2'd0,
    KIND_MINUS     = 2'd1,
    KIND_HEARTBEAT = 2'd2
  } kind_e;

  // One accepted item as handed from the front end to the result stage.
  typedef struct packed {
    logic [TIME_W-1:0]  ts;
    logic [REF_W-1:0]   tref;
    logic [LEVEL_W-1:0] level;
    kind_e              first_kind;
    logic               has_first;
    logic               has_minus;
  } item_t;

  function automatic logic level_accepted(input logic [FILTER_W-1:0] code,
                                          input logic [LEVEL_W-1:0]  lv);
    logic ok;
    case (code)
      FLT_1, FLT_2, FLT_3, FLT_4: ok = ({{(FILTER_W-LEVEL_W){1'b0}}, lv} == code);
      FLT_12:  ok = (lv == LVL_1) || (lv == LVL_2);
      FLT_13:  ok = (lv == LVL_1) || (lv == LVL_3);
      FLT_14:  ok = (lv == LVL_1) || (lv == LVL_4);
      FLT_23:  ok = (lv == LVL_2) || (lv == LVL_3);
      FLT_24:  ok = (lv == LVL_2) || (lv == LVL_4);
      FLT_34:  ok = (lv == LVL_3) || (lv == LVL_4);
      FLT_123: ok = (lv != LVL_4);
      FLT_124: ok = (lv != LVL_3);
      FLT_234: ok = (lv != LVL_1);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cswin_in_if.sv]
`default_nettype none

interface cswin_in_if;
  import cswin_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_heartbeat;
  logic [TIME_W-1:0]  timestamp;
  logic [REF_W-1:0]   tuple_ref;
  logic [LEVEL_W-1:0] tuple_level;

  modport source (output valid, is_heartbeat, timestamp, tuple_ref, tuple_level,
                  input ready);
  modport sink (input valid, is_heartbeat, timestamp, tuple_ref, tuple_level,
                output ready);
endinterface

`default_nettype wire

[rtl/core/cswin_out_if.sv]
`default_nettype none

interface cswin_out_if;
  import cswin_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  out_kind;
  logic [REF_W-1:0]   out_tuple_ref;
  logic [TIME_W-1:0]  out_timestamp;
  logic [LEVEL_W-1:0] out_level;
  logic               last_of_run;

  modport source (output valid, out_kind, out_tuple_ref, out_timestamp, out_level,
                  last_of_run, input ready);
  modport sink (input valid, out_kind, out_tuple_ref, out_timestamp, out_level,
                last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/cswin_cfg_if.sv]
`default_nettype none

interface cswin_cfg_if;
  import cswin_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/cswin_ram.sv]
`default_nettype none

module cswin_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write to one address in the same cycle return
  // the old contents. The read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/cswin_ctrl.sv]
`default_nettype none

module cswin_ctrl #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cswin_in_if.sink                      in_i,
  cswin_cfg_if.sink                     cfg_i,
  input  logic                          emit_ready_i,
  output logic                          item_load_o,
  output cswin_pkg::item_t              item_o,
  output logic                          ram_we_o,
  output logic [$clog2(MAX_WINDOW)-1:0] ram_waddr_o,
  output logic [cswin_pkg::SLOT_W-1:0]  ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(MAX_WINDOW)-1:0] ram_raddr_o
);
  import cswin_pkg::*;

  localparam int unsigned PW = $clog2(MAX_WINDOW);
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CW = (FW > WSIZE_W) ? FW : WSIZE_W;
  localparam logic [CW-1:0] MaxEff  = CW'(MAX_WINDOW);
  localparam logic [PW-1:0] LastPtr = PW'(MAX_WINDOW - 1);
  localparam logic [FW-1:0] MaxFill = FW'(MAX_WINDOW);

  logic [WSIZE_W-1:0]  wsize_q, wsize_d;
  logic [FILTER_W-1:0] filter_q, filter_d;
  logic [PW-1:0]       head_q, head_d;
  logic [PW-1:0]       tail_q, tail_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [TIME_W-1:0]   last_out_q, last_out_d;

  logic          accept;
  logic          cfg_write;
  logic [CW-1:0] ws_ext;
  logic [CW-1:0] eff;
  logic          plus;
  logic          expire;
  logic          beat;

  assign accept    = in_i.valid && in_i.ready;
  assign cfg_write = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = emit_ready_i;
  assign cfg_i.ready = 1'b1;

  // Effective window size: zero acts as one, and it is capped at the memory depth.
  assign ws_ext = CW'(wsize_q);
  always_comb begin
    if (ws_ext == '0) begin
      eff = CW'(1);
    end else if (ws_ext > MaxEff) begin
      eff = MaxEff;
    end else begin
      eff = ws_ext;
    end
  end

  assign plus   = !in_i.is_heartbeat && level_accepted(filter_q, in_i.tuple_level);
  assign expire = plus && (CW'(fill_q) >= eff);
  assign beat   = !plus && (last_out_q < in_i.timestamp);

  always_comb begin
    item_o.ts         = in_i.timestamp;
    item_o.tref       = in_i.tuple_ref;
    item_o.level      = in_i.tuple_level;
    item_o.first_kind = plus ? KIND_PLUS : KIND_HEARTBEAT;
    item_o.has_first  = plus || beat;
    item_o.has_minus  = expire;
  end
  assign item_load_o = accept;

  // The oldest entry is read while the new one is written; when the memory is
  // full both pointers coincide and the read-first memory returns the old tuple.
  assign ram_re_o    = accept && expire;
  assign ram_raddr_o = head_q;
  assign ram_we_o    = accept && plus;
  assign ram_waddr_o = tail_q;
  assign ram_wdata_o = {in_i.tuple_level, in_i.tuple_ref};

  always_comb begin
    wsize_d    = wsize_q;
    filter_d   = filter_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    last_out_d = last_out_q;
    if (cfg_write) begin
      case (cfg_i.index)
        REG_WINDOW_SIZE:  wsize_d  = cfg_i.data[WSIZE_W-1:0];
        REG_LEVEL_FILTER: filter_d = cfg_i.data[FILTER_W-1:0];
        default: ;
      endcase
    end
    if (accept && plus) begin
      last_out_d = in_i.timestamp;
      tail_d     = (tail_q == LastPtr) ? '0 : tail_q + PW'(1);
      if (expire) begin
        head_d = (head_q == LastPtr) ? '0 : head_q + PW'(1);
      end else begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q    <= WSIZE_RESET;
      filter_q   <= FILTER_RESET;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      last_out_q <= '0;
    end else begin
      wsize_q    <= wsize_d;
      filter_q   <= filter_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      last_out_q <= last_out_d;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= MaxFill)
    else $error("window fill count exceeds the memory depth");

  a_expire_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && expire |=> $stable(fill_q))
    else $error("fill count changed on an insert that expired a tuple");

  a_expire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && expire |-> fill_q != '0)
    else $error("tuple expired from an empty window");

endmodule

`default_nettype wire

[rtl/core/cswin_emit.sv]
`default_nettype none

module cswin_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_load_i,
  input  cswin_pkg::item_t             item_i,
  output logic                         ready_o,
  input  logic [cswin_pkg::SLOT_W-1:0] ram_rdata_i,
  cswin_out_if.source                  out_o
);
  import cswin_pkg::*;

  logic               s1_valid_q, s1_valid_d;
  item_t              item_q, item_d;
  logic               phase_q, phase_d;
  logic               out_valid_q, out_valid_d;
  kind_e              kind_q, kind_d;
  logic [REF_W-1:0]   ref_q, ref_d;
  logic [TIME_W-1:0]  ts_q, ts_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               last_q, last_d;

  logic out_free;
  logic s1_last;
  logic s1_emit;
  logic s1_done;

  assign out_free = !out_valid_q || out_o.ready;
  // The minus result, when there is one, follows the plus in the next slot.
  assign s1_last  = phase_q || !item_q.has_minus;
  assign s1_emit  = s1_valid_q && item_q.has_first && out_free;
  assign s1_done  = s1_valid_q && (!item_q.has_first || (out_free && s1_last));
  assign ready_o  = !s1_valid_q || s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    phase_d    = phase_q;
    item_d     = item_q;
    if (item_load_i) begin
      s1_valid_d = 1'b1;
      phase_d    = 1'b0;
      item_d     = item_i;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end else if (s1_emit) begin
      phase_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    ref_d       = ref_q;
    ts_d        = ts_q;
    level_d     = level_q;
    last_d      = last_q;
    if (s1_emit) begin
      out_valid_d = 1'b1;
      ts_d        = item_q.ts;
      last_d      = s1_last;
      if (phase_q) begin
        kind_d  = KIND_MINUS;
        ref_d   = ram_rdata_i[REF_W-1:0];
        level_d = ram_rdata_i[SLOT_W-1 -: LEVEL_W];
      end else if (item_q.first_kind == KIND_PLUS) begin
        kind_d  = KIND_PLUS;
        ref_d   = item_q.tref;
        level_d = item_q.level;
      end else begin
        kind_d  = KIND_HEARTBEAT;
        ref_d   = '0;
        level_d = '0;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    kind_q  <= kind_d;
    ref_q   <= ref_d;
    ts_q    <= ts_d;
    level_q <= level_d;
    last_q  <= last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_kind      = kind_q;
  assign out_o.out_tuple_ref = ref_q;
  assign out_o.out_timestamp = ts_q;
  assign out_o.out_level     = level_q;
  assign out_o.last_of_run   = last_q;

  a_minus_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && phase_q |-> item_q.has_minus)
    else $error("second result slot used by an item without an expired tuple");

  a_minus_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_MINUS |-> last_q)
    else $error("minus result not marked as the last of its run");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_load_i |-> !s1_valid_q || s1_done)
    else $error("item loaded over one whose results are still pending");

endmodule

`default_nettype wire

[rtl/core/count_sliding_window_top.sv]
// Count-based sliding window over a stream of tuples.
// in_i carries one item per handshake: a heartbeat or a tuple insert with its
// timestamp, reference and level. cfg_i writes window_size (index 0) and
// level_filter (index 1); write only while the block is idle.
// out_o delivers results: a plus for each tuple that passes the level filter,
// then a minus for the oldest tuple once the window is full, or a heartbeat
// when an item emits no tuple and the last output time trails its timestamp.
// last_of_run marks the final result of each item.
// Each item is registered in the result stage, its first result then in the
// output register. One item per cycle while the receiver keeps up; an item
// that expires a tuple also holds for its minus, since both results share the
// single output register. The window lives in a one-port-write, one-port-read
// memory of MAX_WINDOW entries; an accepted item that expires a tuple reads it.
// A stalled receiver holds the output register; one further item waits in the
// result stage, and the input stalls behind it.
// Reset sets window_size to 1, passes all levels and empties the window. No
// clearing pass is needed: only entries already written are ever read.
`default_nettype none

module count_sliding_window_top #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cswin_in_if.sink    in_i,
  cswin_out_if.source out_o,
  cswin_cfg_if.sink   cfg_i
);
  import cswin_pkg::*;

  localparam int unsigned PW = $clog2(MAX_WINDOW);

  logic              emit_ready;
  logic              item_load;
  item_t             item;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  cswin_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .emit_ready_i(emit_ready),
    .item_load_o (item_load),
    .item_o      (item),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  cswin_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cswin_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_load_i(item_load),
    .item_i     (item),
    .ready_o    (emit_ready),
    .ram_rdata_i(ram_rdata),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

[bench/tb_count_sliding_window_top.sv]
`timescale 1ns / 1ps

module tb_count_sliding_window_top;
  import cswin_pkg::*;

  localparam int unsigned WIN_DEPTH   = 1024;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYC  = 4;

  typedef struct packed {
    logic               hb;
    logic [TIME_W-1:0]  ts;
    logic [REF_W-1:0]   tref;
    logic [LEVEL_W-1:0] level;
  } win_in_t;

  typedef struct packed {
    kind_e              kind;
    logic [REF_W-1:0]   tref;
    logic [TIME_W-1:0]  ts;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } win_res_t;

  // Tracks the window contents and the stream times, and holds the results
  // the block still owes, oldest first.
  class window_scoreboard #(int unsigned DEPTH = 1024);
    win_res_t          owed_q[$];
    logic [SLOT_W-1:0] slot_mem [DEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    int unsigned       fill;
    logic [TIME_W-1:0] last_in_ts;
    logic [TIME_W-1:0] last_out_ts;
    logic [WSIZE_W-1:0]  win_size;
    logic [FILTER_W-1:0] filter_code;
    int                errors;

    function new();
      head_idx    = 0;
      tail_idx    = 0;
      fill        = 0;
      last_in_ts  = '0;
      last_out_ts = '0;
      win_size    = WSIZE_RESET;
      filter_code = FILTER_RESET;
      errors      = 0;
    endfunction

    function void note_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_WINDOW_SIZE) begin
        win_size = val[WSIZE_W-1:0];
      end else begin
        filter_code = val[FILTER_W-1:0];
      end
    endfunction

    function bit level_passes(input logic [FILTER_W-1:0] code,
                              input logic [LEVEL_W-1:0] lv);
      logic [3:0] lv_mask;
      bit         pass;
      lv_mask = 4'b0000;
      pass    = 1'b0;
      case (code)
        FLT_1:   lv_mask = 4'b0001;
        FLT_2:   lv_mask = 4'b0010;
        FLT_3:   lv_mask = 4'b0100;
        FLT_4:   lv_mask = 4'b1000;
        FLT_12:  lv_mask = 4'b0011;
        FLT_13:  lv_mask = 4'b0101;
        FLT_14:  lv_mask = 4'b1001;
        FLT_23:  lv_mask = 4'b0110;
        FLT_24:  lv_mask = 4'b1010;
        FLT_34:  lv_mask = 4'b1100;
        // The three-digit codes only reject the missing level, so levels
        // outside one to four get through.
        FLT_123: pass = (lv != LVL_4);
        FLT_124: pass = (lv != LVL_3);
        FLT_234: pass = (lv != LVL_1);
        default: pass = 1'b1;
      endcase
      if (lv >= LVL_1 && lv <= LVL_4 && lv_mask[lv - 1]) begin
        pass = 1'b1;
      end
      return pass;
    endfunction

    function void note_input(input win_in_t it);
      win_res_t          res [2];
      int                n;
      int unsigned       eff;
      logic [SLOT_W-1:0] old;
      n = 0;
      if (win_size == 0) begin
        eff = 1;
      end else if (win_size > DEPTH) begin
        eff = DEPTH;
      end else begin
        eff = 32'(win_size);
      end
      last_in_ts = it.ts;
      if (!it.hb && level_passes(filter_code, it.level)) begin
        res[n] = '{kind: KIND_PLUS, tref: it.tref, ts: it.ts, level: it.level,
                   last: 1'b0};
        n++;
        last_out_ts = it.ts;
        // A shrunken window expires exactly one tuple per insert.
        if (fill >= eff && fill > 0) begin
          old      = slot_mem[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          fill--;
          res[n] = '{kind: KIND_MINUS, tref: old[REF_W-1:0], ts: it.ts,
                     level: old[SLOT_W-1:REF_W], last: 1'b0};
          n++;
        end
        slot_mem[tail_idx] = {it.level, it.tref};
        tail_idx = (tail_idx + 1) % DEPTH;
        fill++;
      end else if (last_out_ts < last_in_ts) begin
        res[n] = '{kind: KIND_HEARTBEAT, tref: '0, ts: last_in_ts, level: '0,
                   last: 1'b0};
        n++;
      end
      for (int k = 0; k < n; k++) begin
        res[k].last = (k == n - 1);
        owed_q.push_back(res[k]);
      end
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(input win_res_t got);
      win_res_t want;
      if (owed_q.size() == 0) begin
        report("unexpected result kind", 32'(got.kind), '0);
      end else begin
        want = owed_q.pop_front();
        if (got.kind !== want.kind) report("out_kind", 32'(got.kind), 32'(want.kind));
        if (got.tref !== want.tref) report("out_tuple_ref", got.tref, want.tref);
        if (got.ts !== want.ts) report("out_timestamp", got.ts, want.ts);
        if (got.level !== want.level) report("out_level", 32'(got.level), 32'(want.level));
        if (got.last !== want.last) report("last_of_run", 32'(got.last), 32'(want.last));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cswin_in_if  in_if ();
  cswin_out_if out_if ();
  cswin_cfg_if cfg_if ();

  count_sliding_window_top #(
    .MAX_WINDOW(WIN_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  window_scoreboard #(WIN_DEPTH) sb;

  bit                in_idle;
  bit                out_idle;
  bit                hold_start;
  logic              hold_out;
  int unsigned       cycle_cnt;
  logic [TIME_W-1:0] cur_ts;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Long receiver stall: the block fills up and pushes back on its input.
  initial begin
    hold_out = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        sb.check_result('{kind: kind_e'(out_if.out_kind), tref: out_if.out_tuple_ref,
                          ts: out_if.out_timestamp, level: out_if.out_level,
                          last: out_if.last_of_run});
      end
      if (hold_out) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (out_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic hb, input logic [TIME_W-1:0] ts,
                           input logic [REF_W-1:0] tref,
                           input logic [LEVEL_W-1:0] lv);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.is_heartbeat <= hb;
    in_if.timestamp    <= ts;
    in_if.tuple_ref    <= tref;
    in_if.tuple_level  <= lv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input('{hb: hb, ts: ts, tref: tref, level: lv});
  endtask

  // Registers change only with the block empty; items that produce nothing
  // may still be in flight, hence the short wait after the last result.
  task automatic write_regs(input logic [CFG_DATA_W-1:0] ws_data,
                            input logic [CFG_DATA_W-1:0] flt_data);
    in_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_WINDOW_SIZE;
    cfg_if.data  <= ws_data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.note_config(REG_WINDOW_SIZE, ws_data);
    cfg_if.index <= REG_LEVEL_FILTER;
    cfg_if.data  <= flt_data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.note_config(REG_LEVEL_FILTER, flt_data);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] ws_data,
                           input logic [CFG_DATA_W-1:0] flt_data,
                           input int n_items, input int hb_pct,
                           input bit idle_en, input bit with_hold);
    logic [LEVEL_W-1:0] lv;
    write_regs(ws_data, flt_data);
    in_idle  = idle_en;
    out_idle = idle_en;
    if (with_hold) hold_start = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 19))
        0:             cur_ts = $urandom;
        1:             cur_ts = cur_ts - $urandom_range(1, 50);
        2, 3, 4, 5, 6: cur_ts = cur_ts;
        default:       cur_ts = cur_ts + $urandom_range(1, 100);
      endcase
      lv = ($urandom_range(0, 4) == 0) ? LEVEL_W'($urandom_range(0, 15))
                                       : LEVEL_W'($urandom_range(1, 4));
      send_item($urandom_range(0, 99) < hb_pct, cur_ts, $urandom, lv);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd1023;
      3:       return CFG_DATA_W'($urandom_range(0, 2047));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    logic [FILTER_W-1:0] flt_codes [15];
    flt_codes = '{FLT_1, FLT_2, FLT_3, FLT_4, FLT_12, FLT_13, FLT_14, FLT_23,
                  FLT_24, FLT_34, FLT_123, FLT_124, FLT_234, 8'd0, 8'd255};
    sb         = new();
    cycle_cnt  = 0;
    hold_start = 1'b0;
    in_idle    = 1'b1;
    out_idle   = 1'b1;
    cur_ts     = '0;
    in_if.valid        <= 1'b0;
    in_if.is_heartbeat <= 1'b0;
    in_if.timestamp    <= '0;
    in_if.tuple_ref    <= '0;
    in_if.tuple_level  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_WINDOW_SIZE;
    cfg_if.data        <= '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: window of one, every level passes.
    send_item(1'b1, 32'd0, 32'd0, 4'd0);              // time not advanced
    send_item(1'b1, 32'd3, 32'd0, 4'd0);              // heartbeat
    send_item(1'b0, 32'd3, 32'hFFFF_FFFF, LVL_4);     // plus
    send_item(1'b0, 32'd3, 32'd0, 4'd15);             // plus and minus
    send_item(1'b1, 32'd3, 32'hFFFF_FFFF, 4'd15);     // same time, nothing
    send_item(1'b0, 32'd0, 32'h5A5A_A5A5, LVL_1);     // time going back
    send_item(1'b1, 32'hFFFF_FFFF, 32'd0, 4'd0);      // heartbeat leaves last output
    // Size zero behaves as one.
    write_regs(11'd0, {3'b000, FLT_3});
    send_item(1'b0, 32'd10, 32'h1234_5678, LVL_1);    // dropped, heartbeat
    send_item(1'b0, 32'd10, 32'h8765_4321, LVL_3);
    send_item(1'b0, 32'd9, 32'hDEAD_BEEF, 4'd0);      // dropped, nothing
    // Upper data bits are not part of the filter code.
    write_regs(11'd4, {3'b111, FLT_123});
    send_item(1'b0, 32'd11, 32'h0000_0001, LVL_1);
    send_item(1'b0, 32'd12, 32'h0000_0002, LVL_2);
    send_item(1'b0, 32'd13, 32'h0000_0003, LVL_3);
    send_item(1'b0, 32'd14, 32'h0000_0004, LVL_4);
    send_item(1'b0, 32'd15, 32'h0000_0009, 4'd9);
    // Window shrunk below its fill: each insert expires one tuple.
    write_regs(11'd2, {3'b000, 8'd255});
    send_item(1'b0, 32'd16, 32'hAAAA_5555, LVL_2);
    send_item(1'b0, 32'd17, 32'h5555_AAAA, 4'd8);
    send_item(1'b1, 32'd18, 32'd0, 4'd0);
    cur_ts = 32'd18;

    // Above the maximum size counts as the maximum; fill and wrap the window.
    run_phase(11'd2047, {3'b101, 8'd0}, 1100, 5, 1'b1, 1'b1);
    for (int p = 0; p < 30; p++) begin
      run_phase(pick_window(), {3'($urandom_range(0, 7)), flt_codes[p % 15]},
                30, 20, (p < 26) && (p % 4 != 3), 1'b0);
    end
    in_if.valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
